// ===== rtl/core/lcdnf_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdnf_pkg
// Shared types and constants for the character LCD number formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdnf_pkg;

  localparam int unsigned VAL_W      = 16;
  localparam int unsigned BCD_DIGITS = 5;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned CNT_W      = $clog2(VAL_W + 1);

  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] LINE2_OFFSET = 8'h40;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_A      = 8'h41;
  localparam logic [7:0] ASCII_X      = 8'h78;
  localparam logic [7:0] ASCII_PLUS   = 8'h2B;
  localparam logic [7:0] ASCII_MINUS  = 8'h2D;

  typedef enum logic [2:0] {
    OP_CHAR = 3'd0,
    OP_UDEC = 3'd1,
    OP_SDEC = 3'd2,
    OP_HEX  = 3'd3,
    OP_BIN  = 3'd4
  } op_t;

  typedef struct packed {
    logic load;
    logic shift;
  } bcd_ctrl_t;

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = ASCII_ZERO | {4'h0, nib};
    end else begin
      r = ASCII_A + {4'h0, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lcdnf_bcd.sv =====
// ----------------------------------------------------------------------------
// lcdnf_bcd
// Serial binary to BCD converter, one bit per cycle (shift-and-add-3), with
// the digits read back most significant first through a digit shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnf_bcd (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lcdnf_pkg::bcd_ctrl_t          ctrl,
  input  wire logic [lcdnf_pkg::VAL_W-1:0]   mag,
  output logic                               done,
  output logic [3:0]                         digit
);
  import lcdnf_pkg::*;

  logic [VAL_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [BCD_W-1:0] bcd_adj;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (ctrl.load) begin
      bin_nxt = mag;
      bcd_nxt = '0;
      cnt_nxt = CNT_W'(VAL_W);
    end else if (cnt_r != '0) begin
      bcd_nxt  = {bcd_adj[BCD_W-2:0], bin_r[VAL_W-1]};
      bin_nxt  = {bin_r[VAL_W-2:0], 1'b0};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end else if (ctrl.shift) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'h0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done  = done_r;
  assign digit = bcd_r[BCD_W-1 -: 4];

endmodule

`default_nettype wire

// ===== rtl/core/character_lcd_number_formatter.sv =====
// ----------------------------------------------------------------------------
// character_lcd_number_formatter
// Turns a print request into a run of HD44780-style bus writes.
//
// A request word is taken when start is high and busy is low. Rows 1 and 2
// give a set-cursor command first; any other row gives only characters.
// Opcodes 5 to 7 are dropped and the block stays idle.
// Each bus write appears for one cycle with out_strobe high; out_last marks
// the final write of the request. The receiver cannot stall the block.
// Decimal modes first run a serial binary to BCD conversion, then emit
// one write per cycle, up to 7 writes in all. Char, hex and binary modes
// go straight from idle to the emit state and emit one write per cycle
// from there (1 to 17 writes). busy falls together with the last write,
// so the next request can be taken in the cycle the last write is shown.
// Reset (synchronous, active low) returns the block to idle with no write
// pending.
// ----------------------------------------------------------------------------
`default_nettype none

module character_lcd_number_formatter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [7:0]  in_row,
  input  wire logic [7:0]  in_col,
  input  wire logic [15:0] in_value,
  output logic             out_strobe,
  output logic             out_reg_select,
  output logic [7:0]       out_bus_byte,
  output logic             out_last
);
  import lcdnf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic             cur_pend_r, cur_pend_nxt;
  logic [7:0]       cur_byte_r, cur_byte_nxt;
  logic             neg_r, neg_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [1:0]       pre_left_r, pre_left_nxt;
  logic [4:0]       body_left_r, body_left_nxt;
  logic             strobe_r, strobe_nxt;
  logic             rs_r, rs_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             last_r, last_nxt;

  bcd_ctrl_t        bcd_ctrl;
  logic [VAL_W-1:0] bcd_mag;
  logic             bcd_done;
  logic [3:0]       bcd_digit;
  logic [7:0]       row_off;

  assign row_off = (in_row == 8'd2) ? LINE2_OFFSET : 8'h00;
  assign bcd_mag = (in_opcode == OP_SDEC && in_value[VAL_W-1]) ?
                   VAL_W'(~in_value + 16'd1) : in_value;

  lcdnf_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (bcd_ctrl),
    .mag   (bcd_mag),
    .done  (bcd_done),
    .digit (bcd_digit)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cur_pend_nxt  = cur_pend_r;
    cur_byte_nxt  = cur_byte_r;
    neg_nxt       = neg_r;
    val_nxt       = val_r;
    pre_left_nxt  = pre_left_r;
    body_left_nxt = body_left_r;
    strobe_nxt    = 1'b0;
    rs_nxt        = 1'b1;
    byte_nxt      = byte_r;
    last_nxt      = 1'b0;
    bcd_ctrl      = '0;

    case (state_r)
      S_IDLE: begin
        if (start && in_opcode <= OP_BIN) begin
          op_nxt       = op_t'(in_opcode);
          cur_pend_nxt = (in_row == 8'd1) || (in_row == 8'd2);
          cur_byte_nxt = CMD_SET_ADDR | (in_col - 8'd1 + row_off);
          neg_nxt      = in_value[VAL_W-1];
          val_nxt      = in_value;
          state_nxt    = S_EMIT;
          case (op_t'(in_opcode))
            OP_CHAR: begin
              pre_left_nxt  = 2'd0;
              body_left_nxt = 5'd1;
            end
            OP_UDEC: begin
              pre_left_nxt  = 2'd0;
              body_left_nxt = 5'(BCD_DIGITS);
              bcd_ctrl.load = 1'b1;
              state_nxt     = S_CONV;
            end
            OP_SDEC: begin
              pre_left_nxt  = 2'd1;
              body_left_nxt = 5'(BCD_DIGITS);
              bcd_ctrl.load = 1'b1;
              state_nxt     = S_CONV;
            end
            OP_HEX: begin
              pre_left_nxt  = 2'd2;
              body_left_nxt = 5'(VAL_W / 4);
            end
            default: begin
              pre_left_nxt  = 2'd0;
              body_left_nxt = 5'(VAL_W);
            end
          endcase
        end
      end
      S_CONV: begin
        if (bcd_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        strobe_nxt = 1'b1;
        if (cur_pend_r) begin
          rs_nxt       = 1'b0;
          byte_nxt     = cur_byte_r;
          cur_pend_nxt = 1'b0;
        end else if (pre_left_r != 2'd0) begin
          if (op_r == OP_HEX) begin
            byte_nxt = (pre_left_r == 2'd2) ? ASCII_ZERO : ASCII_X;
          end else begin
            byte_nxt = neg_r ? ASCII_MINUS : ASCII_PLUS;
          end
          pre_left_nxt = pre_left_r - 2'd1;
        end else begin
          case (op_r)
            OP_CHAR: byte_nxt = val_r[7:0];
            OP_UDEC, OP_SDEC: begin
              byte_nxt       = ASCII_ZERO | {4'h0, bcd_digit};
              bcd_ctrl.shift = 1'b1;
            end
            OP_HEX: begin
              byte_nxt = hex_ascii(val_r[VAL_W-1 -: 4]);
              val_nxt  = {val_r[VAL_W-5:0], 4'h0};
            end
            default: begin
              byte_nxt = ASCII_ZERO | {7'h00, val_r[VAL_W-1]};
              val_nxt  = {val_r[VAL_W-2:0], 1'b0};
            end
          endcase
          body_left_nxt = body_left_r - 5'd1;
          if (body_left_r == 5'd1) begin
            last_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
    op_r        <= op_nxt;
    cur_pend_r  <= cur_pend_nxt;
    cur_byte_r  <= cur_byte_nxt;
    neg_r       <= neg_nxt;
    val_r       <= val_nxt;
    pre_left_r  <= pre_left_nxt;
    body_left_r <= body_left_nxt;
    rs_r        <= rs_nxt;
    byte_r      <= byte_nxt;
    last_r      <= last_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = strobe_r;
  assign out_reg_select = rs_r;
  assign out_bus_byte   = byte_r;
  assign out_last       = strobe_r & last_r;

endmodule

`default_nettype wire

// ===== rtl/core/lcdnf_checker.sv =====
// ----------------------------------------------------------------------------
// lcdnf_checker
// Port-level checks on the number formatter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [2:0]  in_opcode,
  input wire logic        out_strobe,
  input wire logic        out_reg_select,
  input wire logic        out_last
);
  import lcdnf_pkg::*;

  a_valid_req_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode <= OP_BIN) |=> busy)
    else $error("valid request did not raise busy");

  a_bad_req_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode > OP_BIN) |=> !busy)
    else $error("dropped request raised busy");

  a_idle_write_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !busy && !$past(start)) |-> out_last)
    else $error("write shown while idle is not the last word");

  a_last_frees : assert property (@(posedge clk) disable iff (!rst_n)
    (out_last && $past(busy)) |-> (!busy || $past(start)))
    else $error("busy held after the last word");

  a_last_is_data : assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_reg_select)
    else $error("last word is a command write");

endmodule

bind character_lcd_number_formatter lcdnf_checker u_lcdnf_checker (.*);

`default_nettype wire
